@@ design/sew_pkg.sv @@
// ----------------------------------------------------------------------------
// sew_pkg
// shared types and constants of the soil evaporation window block
// ----------------------------------------------------------------------------
package sew_pkg;

    localparam int MaxWindow = 64;
    localparam int PtrW      = $clog2(MaxWindow);
    localparam int CountW    = PtrW + 1;
    localparam int WinW      = 7;
    localparam int SlopeW    = 24;
    localparam int HeatW     = 16;
    localparam int EnergyW   = 16;
    localparam int MmW       = 26;
    localparam int NetW      = MmW + 2;
    localparam int FactW     = 17;
    localparam int NetSumW   = NetW + PtrW;
    localparam int EqSumW    = MmW + PtrW + 1;
    localparam int NumW      = 48;
    localparam int DenW      = 43;
    localparam int QuoW      = 64;
    localparam int DivCntW   = 7;

    localparam logic [WinW-1:0]  WinReset = WinW'(32);
    localparam logic [MmW-1:0]   EqFloor  = MmW'(7);
    localparam logic [MmW-1:0]   EqMax    = {MmW{1'b1}};
    localparam logic [FactW-1:0] OneQ16   = FactW'(65536);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIV_EQ,
        ST_SUM,
        ST_DIV_F,
        ST_MUL_F,
        ST_OUT
    } sew_state_t;

endpackage

@@ design/sew_day_if.sv @@
// ----------------------------------------------------------------------------
// sew_day_if
// channel of one day of input data
// ----------------------------------------------------------------------------
interface sew_day_if;
    logic                               valid;
    logic                               ready;
    logic                               restart;
    logic [sew_pkg::SlopeW-1:0]         slope_ratio;
    logic [sew_pkg::HeatW-1:0]          latent_heat;
    logic signed [sew_pkg::EnergyW-1:0] avail_energy;
    logic [sew_pkg::MmW-1:0]            prec;
    logic [sew_pkg::MmW-1:0]            interception;

    modport source (output valid, restart, slope_ratio, latent_heat, avail_energy,
                    prec, interception, input ready);
    modport sink (input valid, restart, slope_ratio, latent_heat, avail_energy,
                  prec, interception, output ready);
endinterface

@@ design/sew_result_if.sv @@
// ----------------------------------------------------------------------------
// sew_result_if
// channel of one day of results
// ----------------------------------------------------------------------------
interface sew_result_if;
    logic                         valid;
    logic                         ready;
    logic [sew_pkg::MmW-1:0]      equilibrium_evap;
    logic [sew_pkg::FactW-1:0]    moisture_factor;
    logic [sew_pkg::MmW-1:0]      soil_evap;

    modport source (output valid, equilibrium_evap, moisture_factor, soil_evap,
                    input ready);
    modport sink (input valid, equilibrium_evap, moisture_factor, soil_evap,
                  output ready);
endinterface

@@ design/soil_evaporation_window.sv @@
// work per day: 64 divider steps for the evaporation, the window sums over k days
// (k = days summed, 0 to 64), 50 divider steps for the factor and one shared
// 32x32 multiplier pass per product
// a new day is taken only once the result of the last one is handed over
// reset: asynchronous, clears control, the day count and write pointer, and sets win_reg to 32;
// ring memories hold no reset value and their data are used only after being written
// ----------------------------------------------------------------------------
// soil_evaporation_window
// equilibrium soil evaporation and moisture factor over a sliding day window
// ----------------------------------------------------------------------------
module soil_evaporation_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sew_pkg::WinW-1:0]   cfg_wdata,
    sew_day_if.sink                    day,
    sew_result_if.source               result
);

    sew_pkg::sew_state_t state_reg, state_next;

    logic [sew_pkg::WinW-1:0]    win_reg;
    logic [sew_pkg::CountW-1:0]  count_reg, count_next;
    logic [sew_pkg::PtrW-1:0]    wptr_reg, wptr_next;

    logic [sew_pkg::NetW-1:0]    net_ring [sew_pkg::MaxWindow];
    logic [sew_pkg::MmW-1:0]     eq_ring  [sew_pkg::MaxWindow];

    // latched day
    logic                        rst_in_reg;
    logic [sew_pkg::SlopeW-1:0]  s_reg;
    logic [sew_pkg::HeatW-1:0]   l_reg;
    logic [sew_pkg::EnergyW-1:0] a_reg;
    logic signed [sew_pkg::NetW-1:0] net_today_reg;

    logic [sew_pkg::NumW-1:0]    num_reg;
    logic [sew_pkg::MmW-1:0]     eq_reg;
    logic [sew_pkg::FactW-1:0]   fact_reg;
    logic [sew_pkg::MmW-1:0]     soil_reg;

    logic signed [sew_pkg::NetSumW-1:0] nsum_reg;
    logic [sew_pkg::EqSumW-1:0]         esum_reg;
    logic [sew_pkg::CountW-1:0]         k_reg;
    logic [sew_pkg::PtrW-1:0]           rptr_reg;
    logic                               rd_pend_reg;
    logic [sew_pkg::NetW-1:0]           rd_net_reg;
    logic [sew_pkg::MmW-1:0]            rd_eq_reg;

    // shared divider: remainder, quotient, divisor, step counter
    logic [sew_pkg::DenW:0]       rem_reg;
    logic [sew_pkg::QuoW-1:0]     quo_reg;
    logic [sew_pkg::DenW-1:0]     dvs_reg;
    logic [sew_pkg::DivCntW-1:0]  dcnt_reg;
    logic [sew_pkg::DenW:0]       rem_shift;
    logic                         rem_ge;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    logic [sew_pkg::WinW-1:0]   w_eff;
    logic [sew_pkg::CountW-1:0] w_cnt;
    logic signed [15:0]         a_s;
    logic [sew_pkg::HeatW-1:0]  l_eff;

    assign w_eff = (win_reg == '0) ? sew_pkg::WinW'(1)
                 : (win_reg > sew_pkg::WinW'(sew_pkg::MaxWindow))
                   ? sew_pkg::WinW'(sew_pkg::MaxWindow) : win_reg;
    assign w_cnt = sew_pkg::CountW'(w_eff);
    assign a_s   = signed'(a_reg);
    assign l_eff = (l_reg == '0) ? sew_pkg::HeatW'(1) : l_reg;

    assign rem_shift = {rem_reg[sew_pkg::DenW-1:0], quo_reg[sew_pkg::QuoW-1]};
    assign rem_ge    = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            sew_pkg::ST_MUL_A:
            begin
                mul_a = 32'(s_reg);
                mul_b = 32'(unsigned'(a_s[14:0])) * 32'd432;
            end
            sew_pkg::ST_MUL_B:
            begin
                mul_a = 32'(s_reg) + 32'd65536;
                mul_b = 32'(l_eff) * 32'd5;
            end
            sew_pkg::ST_MUL_F:
            begin
                mul_a = 32'(fact_reg);
                mul_b = 32'(eq_reg);
            end
            default: ;
        endcase
    end

    assign day.ready = (state_reg == sew_pkg::ST_IDLE);
    assign result.valid = (state_reg == sew_pkg::ST_OUT);
    assign result.equilibrium_evap = eq_reg;
    assign result.moisture_factor  = fact_reg;
    assign result.soil_evap        = soil_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        wptr_next  = wptr_reg;
        case (state_reg)
            sew_pkg::ST_IDLE:
                if (day.valid)
                    state_next = sew_pkg::ST_MUL_A;
            sew_pkg::ST_MUL_A:
                state_next = sew_pkg::ST_MUL_B;
            sew_pkg::ST_MUL_B:
                state_next = sew_pkg::ST_DIV_EQ;
            sew_pkg::ST_DIV_EQ:
                if (dcnt_reg == '0)
                    state_next = sew_pkg::ST_SUM;
            sew_pkg::ST_SUM:
                if (k_reg == '0 && !rd_pend_reg)
                    state_next = sew_pkg::ST_DIV_F;
            sew_pkg::ST_DIV_F:
                if (dcnt_reg == '0)
                    state_next = sew_pkg::ST_MUL_F;
            sew_pkg::ST_MUL_F:
            begin
                state_next = sew_pkg::ST_OUT;
                wptr_next  = wptr_reg + 1'b1;
                if (count_reg != sew_pkg::CountW'(sew_pkg::MaxWindow))
                    count_next = count_reg + 1'b1;
            end
            sew_pkg::ST_OUT:
                if (result.ready)
                    state_next = sew_pkg::ST_IDLE;
            default:
                state_next = sew_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sew_pkg::ST_IDLE;
            win_reg   <= sew_pkg::WinReset;
            count_reg <= '0;
            wptr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                win_reg <= cfg_wdata;
            if (state_reg == sew_pkg::ST_IDLE && day.valid && day.restart)
            begin
                count_reg <= '0;
                wptr_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                wptr_reg  <= wptr_next;
            end
        end
    end

    // ring memories
    always_ff @(posedge clk)
    begin
        if (state_reg == sew_pkg::ST_MUL_F)
        begin
            net_ring[wptr_reg] <= net_today_reg;
            eq_ring[wptr_reg]  <= eq_reg;
        end
        rd_net_reg <= net_ring[rptr_reg];
        rd_eq_reg  <= eq_ring[rptr_reg];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sew_pkg::ST_IDLE:
            begin
                rst_in_reg    <= day.restart;
                s_reg         <= day.slope_ratio;
                l_reg         <= day.latent_heat;
                a_reg         <= day.avail_energy;
                net_today_reg <= signed'({2'b00, day.prec}) - signed'({2'b00, day.interception});
            end
            sew_pkg::ST_MUL_A:
                num_reg <= sew_pkg::NumW'(mul_p);
            sew_pkg::ST_MUL_B:
            begin
                dvs_reg  <= sew_pkg::DenW'(mul_p);
                rem_reg  <= '0;
                quo_reg  <= {num_reg, 16'h0};
                dcnt_reg <= sew_pkg::DivCntW'(sew_pkg::QuoW - 1);
            end
            sew_pkg::ST_DIV_EQ, sew_pkg::ST_DIV_F:
            begin
                rem_reg  <= rem_ge ? rem_shift - {1'b0, dvs_reg} : rem_shift;
                quo_reg  <= {quo_reg[sew_pkg::QuoW-2:0], rem_ge};
                dcnt_reg <= dcnt_reg - 1'b1;
                if (state_reg == sew_pkg::ST_DIV_EQ && dcnt_reg == '0)
                begin
                    if (a_s <= 0 || s_reg == '0)
                        eq_reg <= sew_pkg::EqFloor;
                    else if ({quo_reg[sew_pkg::QuoW-2:0], rem_ge} > sew_pkg::QuoW'(sew_pkg::EqMax))
                        eq_reg <= sew_pkg::EqMax;
                    else if ({quo_reg[sew_pkg::QuoW-2:0], rem_ge} < sew_pkg::QuoW'(sew_pkg::EqFloor))
                        eq_reg <= sew_pkg::EqFloor;
                    else
                        eq_reg <= sew_pkg::MmW'({quo_reg[sew_pkg::QuoW-2:0], rem_ge});
                    // window setup
                    rptr_reg    <= wptr_reg - 1'b1;
                    rd_pend_reg <= 1'b0;
                    nsum_reg    <= '0;
                    esum_reg    <= '0;
                    if (rst_in_reg || count_reg == '0)
                        k_reg <= '0;
                    else
                        k_reg <= (count_reg < w_cnt) ? count_reg : w_cnt;
                end
                if (state_reg == sew_pkg::ST_DIV_F && dcnt_reg == '0)
                begin
                    if (nsum_reg <= 0)
                        fact_reg <= '0;
                    else if (sew_pkg::EqSumW'(unsigned'(nsum_reg)) >= esum_reg)
                        fact_reg <= sew_pkg::OneQ16;
                    else
                        fact_reg <= sew_pkg::FactW'({quo_reg[sew_pkg::QuoW-2:0], rem_ge});
                end
            end
            sew_pkg::ST_SUM:
            begin
                // one read per cycle, accumulate the data from the read register
                if (rd_pend_reg)
                begin
                    nsum_reg <= nsum_reg + sew_pkg::NetSumW'(signed'(rd_net_reg));
                    esum_reg <= esum_reg + sew_pkg::EqSumW'(rd_eq_reg);
                end
                rd_pend_reg <= (k_reg != '0);
                if (k_reg != '0)
                begin
                    k_reg    <= k_reg - 1'b1;
                    rptr_reg <= rptr_reg - 1'b1;
                end
                if (k_reg == '0 && !rd_pend_reg)
                begin
                    if (rst_in_reg || count_reg == '0)
                    begin
                        nsum_reg <= sew_pkg::NetSumW'(net_today_reg);
                        esum_reg <= sew_pkg::EqSumW'(eq_reg);
                        dvs_reg  <= sew_pkg::DenW'(eq_reg);
                        quo_reg  <= {sew_pkg::NetSumW'(net_today_reg), 16'h0,
                                     {(sew_pkg::QuoW - sew_pkg::NetSumW - 16){1'b0}}};
                    end
                    else
                    begin
                        dvs_reg <= sew_pkg::DenW'(esum_reg);
                        quo_reg <= {nsum_reg, 16'h0,
                                    {(sew_pkg::QuoW - sew_pkg::NetSumW - 16){1'b0}}};
                    end
                    rem_reg  <= '0;
                    dcnt_reg <= sew_pkg::DivCntW'(sew_pkg::NetSumW + 16 - 1);
                end
            end
            sew_pkg::ST_MUL_F:
                soil_reg <= sew_pkg::MmW'(mul_p >> 16);
            default: ;
        endcase
    end

endmodule

@@ design/sew_checker.sv @@
// ----------------------------------------------------------------------------
// sew_checker
// port level checks of the soil evaporation window block
// ----------------------------------------------------------------------------
module sew_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [sew_pkg::MmW-1:0]   equilibrium_evap,
    input logic [sew_pkg::FactW-1:0] moisture_factor,
    input logic [sew_pkg::MmW-1:0]   soil_evap
);

    // no new input while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    // a transfer in never shows a result on the next edge
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    a_fact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> moisture_factor <= sew_pkg::OneQ16) else $error("factor above one");

    a_eq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (equilibrium_evap >= sew_pkg::EqFloor && soil_evap <= equilibrium_evap))
        else $error("evaporation out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(soil_evap)))
        else $error("result dropped while stalled");

endmodule

bind soil_evaporation_window sew_checker u_sew_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (day.valid),
    .in_ready         (day.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .equilibrium_evap (result.equilibrium_evap),
    .moisture_factor  (result.moisture_factor),
    .soil_evap        (result.soil_evap)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives random and corner days into the soil evaporation window block and
// checks every result against a behavioral prediction of equilibrium
// evaporation, moisture factor and soil evaporation over the day window
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [sew_pkg::MmW-1:0]   eq;
        logic [sew_pkg::FactW-1:0] fact;
        logic [sew_pkg::MmW-1:0]   soil;
    } day_result_t;

    class evap_scoreboard;
        longint net_hist[sew_pkg::MaxWindow];
        longint eq_hist[sew_pkg::MaxWindow];
        int days_stored;
        int slot;
        int win;
        day_result_t pending[$];
        int errors;

        function void clear();
            days_stored = 0;
            slot = 0;
            win = 32;
            errors = 0;
            pending.delete();
        endfunction

        function longint equilibrium(longint s, longint l, logic [15:0] e_code);
            longint a;
            longint num;
            longint den;
            longint q;
            a = longint'($signed(e_code));
            if (l == 0)
                l = 1;
            if (a <= 0 || s == 0)
                return 7;
            num = s * a * 432;
            den = (s + 65536) * l * 5;
            q = ((num / den) << 16) + (((num % den) << 16) / den);
            if (q > 67108863)
                q = 67108863;
            if (q < 7)
                q = 7;
            return q;
        endfunction

        function void note_day(logic rs, logic [23:0] s, logic [15:0] l, logic [15:0] e,
                               logic [25:0] p, logic [25:0] ic);
            longint net_today;
            longint eq_today;
            longint nsum;
            longint esum;
            longint f;
            int w;
            int k;
            int idx;
            day_result_t r;
            net_today = longint'(p) - longint'(ic);
            eq_today = equilibrium(longint'(s), longint'(l), e);
            w = win == 0 ? 1 : (win > sew_pkg::MaxWindow ? sew_pkg::MaxWindow : win);
            if (rs)
            begin
                days_stored = 0;
                slot = 0;
            end
            if (days_stored == 0)
            begin
                nsum = net_today;
                esum = eq_today;
            end
            else
            begin
                k = days_stored < w ? days_stored : w;
                nsum = 0;
                esum = 0;
                idx = slot;
                for (int i = 0; i < k; i++)
                begin
                    idx = idx == 0 ? sew_pkg::MaxWindow - 1 : idx - 1;
                    nsum += net_hist[idx];
                    esum += eq_hist[idx];
                end
            end
            if (nsum <= 0)
                f = 0;
            else if (nsum >= esum)
                f = 65536;
            else
                f = (nsum << 16) / esum;
            net_hist[slot] = net_today;
            eq_hist[slot] = eq_today;
            slot = (slot + 1) % sew_pkg::MaxWindow;
            if (days_stored < sew_pkg::MaxWindow)
                days_stored++;
            r.eq = eq_today[sew_pkg::MmW-1:0];
            r.fact = f[sew_pkg::FactW-1:0];
            r.soil = sew_pkg::MmW'((f * eq_today) >> 16);
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch: %s at %0t", what, $realtime);
            errors++;
        endtask

        task check_result(day_result_t got);
            day_result_t want;
            if (pending.size() == 0)
            begin
                report("result with no day pending");
                return;
            end
            want = pending.pop_front();
            if (got.eq !== want.eq)
                report($sformatf("equilibrium_evap got %0d want %0d", got.eq, want.eq));
            if (got.fact !== want.fact)
                report($sformatf("moisture_factor got %0d want %0d", got.fact, want.fact));
            if (got.soil !== want.soil)
                report($sformatf("soil_evap got %0d want %0d", got.soil, want.soil));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sew_pkg::WinW-1:0] cfg_wdata;
    int send_idle;
    int recv_stall;
    bit hold_off;
    evap_scoreboard sb;

    sew_day_if day ();
    sew_result_if result ();

    soil_evaporation_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .day       (day.sink),
        .result    (result.sink)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("FAIL soil_evaporation_window");
        $finish;
    end

    // receiver side: random stalls, plus a long hold-off on request
    initial
    begin
        day_result_t got;
        result.ready = 0;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                got.eq = result.equilibrium_evap;
                got.fact = result.moisture_factor;
                got.soil = result.soil_evap;
                sb.check_result(got);
            end
            if (hold_off)
                result.ready <= 0;
            else
                result.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // valid stays up between back-to-back days, drops only while idling
    task send_day(logic rs, logic [23:0] s, logic [15:0] l, logic [15:0] e,
                  logic [25:0] p, logic [25:0] ic);
        while ($urandom_range(99) < send_idle)
        begin
            day.valid <= 0;
            @(posedge clk);
        end
        day.valid <= 1;
        day.restart <= rs;
        day.slope_ratio <= s;
        day.latent_heat <= l;
        day.avail_energy <= e;
        day.prec <= p;
        day.interception <= ic;
        do
            @(posedge clk);
        while (!day.ready);
        sb.note_day(rs, s, l, e, p, ic);
    endtask

    task drain();
        day.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task set_window(logic [sew_pkg::WinW-1:0] w);
        drain();
        cfg_we <= 1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 0;
        sb.win = int'(w);
    endtask

    // mostly realistic days, sometimes full-range codes
    task random_day(int restart_pct);
        logic [23:0] s;
        logic [15:0] l;
        logic [15:0] e;
        logic [25:0] p;
        logic [25:0] ic;
        if ($urandom_range(9) < 7)
        begin
            s = 24'($urandom_range(400000, 1000));
            l = 16'($urandom_range(40000, 36000));
            e = 16'($urandom_range(4000, 0));
            p = $urandom_range(3) == 0 ? 26'($urandom_range(1500000))
                                       : 26'($urandom_range(20000));
            ic = 26'($urandom_range(200000));
        end
        else
        begin
            s = 24'($urandom);
            l = 16'($urandom);
            e = 16'($urandom);
            p = 26'($urandom);
            ic = 26'($urandom);
        end
        send_day($urandom_range(99) < restart_pct, s, l, e, p, ic);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        day.valid = 0;
        day.restart = 0;
        day.slope_ratio = '0;
        day.latent_heat = '0;
        day.avail_energy = '0;
        day.prec = '0;
        day.interception = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // first day after reset without restart, then corners
        send_day(0, 24'd65536, 16'd38000, 16'd2000, 26'd500000, 26'd1000);
        send_day(0, 24'hFFFFFF, 16'd1, 16'h7FFF, 26'h3FFFFFF, 26'd0);
        send_day(0, 24'd0, 16'd38000, 16'd3000, 26'd0, 26'h3FFFFFF);
        send_day(0, 24'd70000, 16'd0, 16'd100, 26'd10, 26'd5);
        send_day(0, 24'd70000, 16'hFFFF, 16'h8000, 26'd1000, 26'd0);
        send_day(0, 24'd1, 16'hFFFF, 16'd1, 26'd0, 26'd0);
        send_day(0, 24'h800000, 16'd20000, 16'hFFFF, 26'h2000000, 26'h1000000);
        send_day(1, 24'd65536, 16'd38000, 16'd2000, 26'd0, 26'd100);
        send_day(0, 24'd65536, 16'd38000, 16'd2000, 26'd200000, 26'd0);
        send_day(1, 24'h555555, 16'hAAAA, 16'h5555, 26'h2AAAAAA, 26'h1555555);

        set_window(7'd0);
        repeat (4) random_day(0);
        set_window(7'd127);
        repeat (70) random_day(0);
        set_window(7'd64);
        repeat (10) random_day(0);
        set_window(7'd1);
        repeat (10) random_day(20);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = ph == 1 || ph == 3 ? (ph == 1 ? 74 : 14) : 0;
            recv_stall = ph == 2 || ph == 3 ? (ph == 2 ? 74 : 14) : 0;
            set_window(sew_pkg::WinW'($urandom_range(64, 1)));
            for (int i = 0; i < 325; i++)
                random_day(i % 150 == 0 ? 100 : 2);
        end

        // long receiver hold-off while days keep coming
        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                hold_off = 1;
                repeat (2000) @(posedge clk);
                hold_off = 0;
            end
            repeat (5) random_day(0);
        join

        drain();
        if (sb.errors == 0)
            $display("PASS soil_evaporation_window");
        else
            $display("FAIL soil_evaporation_window");
        $finish;
    end
endmodule
